// ===== src/fp32mfq_pkg.sv =====
// Package: format codes and the per-format encode/decode functions of the quantizer.
`default_nettype none
package fp32mfq_pkg;

   typedef enum logic [2:0] {
      FMT_BF16 = 3'd0,
      FMT_F16  = 3'd1,
      FMT_TF32 = 3'd2,
      FMT_E4M3 = 3'd3,
      FMT_E5M2 = 3'd4
   } format_type;

   localparam int unsigned FORMAT_WIDTH = 3;
   localparam logic [FORMAT_WIDTH-1:0] FORMAT_RESET = FMT_BF16;

   // f16 exponent rebias (127 - 15) and fp8 rebias offsets (127 - bias)
   localparam logic [7:0] F16_REBIAS  = 8'd112;
   localparam logic [7:0] F16_EXP_TOP = 8'd143;
   localparam logic [8:0] E4M3_REBIAS = 9'd120;
   localparam logic [8:0] E4M3_TOP    = 9'd135;
   localparam logic [8:0] E5M2_REBIAS = 9'd112;
   localparam logic [8:0] E5M2_TOP    = 9'd143;

   // bf16: nearest-even by add-and-truncate, 32-bit wrap
   function automatic logic [15:0] enc_bf16(input logic [31:0] x);
      logic [31:0] y;
      begin
         y = x + 32'h0000_7fff + {31'd0, x[16]};
         return y[31:16];
      end
   endfunction

   function automatic logic [31:0] enc_tf32(input logic [31:0] x);
      logic [31:0] y;
      begin
         y = x + 32'h0000_0fff + {31'd0, x[13]};
         return {y[31:13], 13'd0};
      end
   endfunction

   // f16: round half up on bit 12, carry runs into the exponent
   function automatic logic [15:0] enc_f16(input logic [31:0] x);
      logic [7:0] ef;
      logic [7:0] eb;
      begin
         ef = x[30:23];
         eb = ef - F16_REBIAS;
         if (ef <= F16_REBIAS) begin
            return {x[31], 15'd0};
         end else if (ef >= F16_EXP_TOP) begin
            return {x[31], 15'h7c00};
         end else begin
            return {x[31], eb[4:0], 10'd0} + {6'd0, x[22:13]} + {15'd0, x[12]};
         end
      end
   endfunction

   function automatic logic [31:0] dec_f16(input logic [15:0] h);
      logic [7:0] e8;
      begin
         e8 = {3'd0, h[14:10]} + F16_REBIAS;
         if (h[14:10] == 5'd0) begin
            return {h[15], 31'd0};
         end else if (h[14:10] == 5'h1f) begin
            return {h[15], 8'hff, h[9:0], 13'd0};
         end else begin
            return {h[15], e8, h[9:0], 13'd0};
         end
      end
   endfunction

   function automatic logic [7:0] enc_e4m3(input logic [31:0] x);
      logic [4:0] mant;
      logic       rnd;
      logic [8:0] t;
      logic [8:0] eo;
      begin
         rnd  = x[19] & ((x[18:0] != 19'd0) | x[20]);
         mant = {2'b01, x[22:20]} + {4'd0, rnd};
         t    = {1'b0, x[30:23]} + {8'd0, mant[4]};
         eo   = t - E4M3_REBIAS;
         if (x[30:23] == 8'd0 || t <= E4M3_REBIAS) begin
            return {x[31], 7'd0};
         end else if (t >= E4M3_TOP) begin
            return {x[31], 4'd14, 3'b111};
         end else begin
            return {x[31], eo[3:0], mant[2:0]};
         end
      end
   endfunction

   function automatic logic [7:0] enc_e5m2(input logic [31:0] x);
      logic [3:0] mant;
      logic       rnd;
      logic [8:0] t;
      logic [8:0] eo;
      begin
         rnd  = x[20] & ((x[19:0] != 20'd0) | x[21]);
         mant = {2'b01, x[22:21]} + {3'd0, rnd};
         t    = {1'b0, x[30:23]} + {8'd0, mant[3]};
         eo   = t - E5M2_REBIAS;
         if (x[30:23] == 8'd0 || t <= E5M2_REBIAS) begin
            return {x[31], 7'd0};
         end else if (t >= E5M2_TOP) begin
            return {x[31], 5'd30, 2'b11};
         end else begin
            return {x[31], eo[4:0], mant[1:0]};
         end
      end
   endfunction

   function automatic logic [31:0] dec_e4m3(input logic [7:0] b);
      logic [8:0] e9;
      begin
         e9 = {5'd0, b[6:3]} + E4M3_REBIAS;
         if (b[6:3] == 4'd0) begin
            return {b[7], 31'd0};
         end else begin
            return {b[7], e9[7:0], b[2:0], 20'd0};
         end
      end
   endfunction

   function automatic logic [31:0] dec_e5m2(input logic [7:0] b);
      logic [8:0] e9;
      begin
         e9 = {4'd0, b[6:2]} + E5M2_REBIAS;
         if (b[6:2] == 5'd0) begin
            return {b[7], 31'd0};
         end else begin
            return {b[7], e9[7:0], b[1:0], 21'd0};
         end
      end
   endfunction

endpackage
`default_nettype wire

// ===== src/fp32_multi_format_quantizer_unit.sv =====
// Top level: three-stage pipelined fp32 to bf16/f16/tf32/e4m3/e5m2 quantizer.
// Usage:
//  - csr_wr_en/csr_wr_data load the 3-bit format register (0 bf16, 1 f16,
//    2 tf32, 3 e4m3, 4 e5m2; other codes return zeros). Write it only idle.
//  - req channel: one fp32 bit pattern per transaction (req_value_bits).
//  - rsp channel: narrow code (rsp_code) and the fp32 bits of its decoded
//    value (rsp_dequant_bits), one transaction per request, in order.
// Pipeline: three register stages (input register, encode register, decode/output register).
// Throughput: one transaction per cycle while rsp_stall is low; each stage is a
// single register with its own valid bit, so bubbles close up under stall.
// Stall: when rsp_stall holds the output, upstream stages keep filling; once
// all three hold data req_stall rises. Nothing is dropped or repeated.
// Reset: synchronous, clears all valid bits and sets the format to bf16.
`default_nettype none
module fp32_multi_format_quantizer_unit
   import fp32mfq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [FORMAT_WIDTH-1:0] csr_wr_data,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [31:0]             req_value_bits,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [31:0]                  rsp_code,
   output logic [31:0]                  rsp_dequant_bits
);

   logic [FORMAT_WIDTH-1:0] format_ff;

   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [31:0]             s1_x_ff;
   logic [FORMAT_WIDTH-1:0] s1_fmt_ff, s2_fmt_ff;
   logic [31:0]             s2_code_ff, s2_code_in;
   logic [31:0]             s3_code_ff, s3_deq_ff, s3_deq_in;
   logic                    en1, en2, en3;

   assign en3 = !s3_valid_ff || !rsp_stall;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff   <= FORMAT_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            format_ff <= csr_wr_data;
         end
         if (en1) begin
            s1_valid_ff <= req_valid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // encode stage
   always_comb begin
      case (s1_fmt_ff)
         FMT_BF16: s2_code_in = {16'd0, enc_bf16(s1_x_ff)};
         FMT_F16:  s2_code_in = {16'd0, enc_f16(s1_x_ff)};
         FMT_TF32: s2_code_in = enc_tf32(s1_x_ff);
         FMT_E4M3: s2_code_in = {24'd0, enc_e4m3(s1_x_ff)};
         FMT_E5M2: s2_code_in = {24'd0, enc_e5m2(s1_x_ff)};
         default:  s2_code_in = 32'd0;
      endcase
   end

   // decode stage
   always_comb begin
      case (s2_fmt_ff)
         FMT_BF16: s3_deq_in = {s2_code_ff[15:0], 16'd0};
         FMT_F16:  s3_deq_in = dec_f16(s2_code_ff[15:0]);
         FMT_TF32: s3_deq_in = s2_code_ff;
         FMT_E4M3: s3_deq_in = dec_e4m3(s2_code_ff[7:0]);
         FMT_E5M2: s3_deq_in = dec_e5m2(s2_code_ff[7:0]);
         default:  s3_deq_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_x_ff   <= req_value_bits;
         s1_fmt_ff <= format_ff;
      end
      if (en2) begin
         s2_code_ff <= s2_code_in;
         s2_fmt_ff  <= s1_fmt_ff;
      end
      if (en3) begin
         s3_code_ff <= s2_code_ff;
         s3_deq_ff  <= s3_deq_in;
      end
   end

   assign rsp_valid        = s3_valid_ff;
   assign rsp_code         = s3_code_ff;
   assign rsp_dequant_bits = s3_deq_ff;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the fp32 multi-format quantizer: random and corner operands, self-checking.
`timescale 1ns / 100ps
module tb
   import fp32mfq_pkg::*;
;

   localparam logic [2:0] FMT_SPARE_LO  = 3'd5;
   localparam logic [2:0] FMT_SPARE_MID = 3'd6;
   localparam logic [2:0] FMT_SPARE_HI  = 3'd7;
   localparam int FP32_BIAS     = 127;
   localparam int F16_EXP_SHIFT = 112;
   localparam int RANDOM_CHUNK  = 51;
   localparam int DRAIN_CYCLES  = 8;
   localparam int STUCK_LIMIT   = 2000;
   localparam int NUM_EDGE      = 25;

   localparam logic [31:0] EDGE_OPERANDS [0:NUM_EDGE-1] = '{
      32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807f_ffff, // zeros, denormals
      32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'h7fff_ffff, // inf, NaN
      32'hffff_ffff,                                              // bf16 wraps to zero
      32'h3f80_0000, 32'h3f80_8000, 32'h3f81_8000,                // 1.0, bf16 ties
      32'h3f80_1000, 32'h3f80_3000,                               // half on bit 12
      32'h477f_e000, 32'h477f_f000, 32'h3880_0000, 32'h3800_0000, // f16 max, carry, min
      32'h43e0_0000, 32'h43f0_0000, 32'h3c80_0000, 32'h3c7f_ffff, // e4m3 limits
      32'h4760_0000, 32'hc780_0000, 32'h387f_ffff                 // e5m2 limits
   };

   typedef struct packed {
      logic [31:0] code;
      logic [31:0] dequant_bits;
   } quant_result_type;

   typedef enum logic [1:0] {
      PACE_SINK_HEAVY,
      PACE_SOURCE_HEAVY,
      PACE_FREE
   } pace_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_wr_en      = 1'b0;
   logic [2:0]  csr_wr_data    = 3'd0;
   logic        req_valid      = 1'b0;
   logic [31:0] req_value_bits = 32'd0;
   logic        rsp_stall      = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [31:0] rsp_code;
   logic [31:0] rsp_dequant_bits;

   logic [31:0]      operand_queue [$];
   quant_result_type expected_quant [$];
   logic [2:0]       active_format = FMT_BF16;
   pace_type         pace          = PACE_SINK_HEAVY;
   int               n_pushed      = 0;
   int               n_accepted    = 0;
   int               mismatches    = 0;
   int               stuck_cycles  = 0;

   fp32_multi_format_quantizer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value_bits   (req_value_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code         (rsp_code),
      .rsp_dequant_bits (rsp_dequant_bits)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- prediction ----------------

   // round half up on bit 12; mantissa carry runs into the exponent
   function automatic logic [15:0] f16_encode(input logic [31:0] x);
      logic [15:0] sgn;
      logic [15:0] mm;
      int          e;
      sgn = {x[31], 15'd0};
      e   = int'(x[30:23]) - F16_EXP_SHIFT;
      if (e <= 0) return sgn;
      if (e >= 31) return sgn | 16'h7c00;
      mm = {6'd0, x[22:13]} + 16'(x[12]);
      return (sgn | 16'(e << 10)) + mm;
   endfunction

   function automatic logic [31:0] f16_decode(input logic [15:0] h);
      logic [4:0] e;
      e = h[14:10];
      if (e == 5'd0) return {h[15], 31'd0};
      if (e == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
      return {h[15], 8'(int'(e) + F16_EXP_SHIFT), h[9:0], 13'd0};
   endfunction

   function automatic logic [7:0] fp8_encode(input logic [31:0] x, input int unsigned eb,
                                             input int unsigned mb, input int bias);
      logic [7:0]  sgn;
      int unsigned full, mant, rem, half, shift;
      int          eo, maxe;
      sgn   = 8'(x[31]) << (eb + mb);
      maxe  = (1 << eb) - 1;
      shift = 23 - mb;
      if (x[30:23] == 8'd0) return sgn;
      eo   = int'(x[30:23]) - FP32_BIAS + bias;
      full = {9'd1, x[22:0]};
      mant = full >> shift;
      rem  = full & ((1 << shift) - 1);
      half = 1 << (shift - 1);
      if (rem > half || (rem == half && (mant & 1) != 0)) mant++;
      if (mant >= (2 << mb)) begin
         mant = mant >> 1;
         eo++;
      end
      if (eo <= 0) return sgn;
      // overflow, inf and NaN saturate to the largest finite code
      if (eo >= maxe) return sgn | 8'((maxe - 1) << mb) | 8'((1 << mb) - 1);
      return sgn | 8'(eo << mb) | 8'(mant & ((1 << mb) - 1));
   endfunction

   function automatic logic [31:0] fp8_decode(input logic [7:0] b, input int unsigned eb,
                                              input int unsigned mb, input int bias);
      int unsigned e, m;
      e = (b >> mb) & ((1 << eb) - 1);
      m = b & ((1 << mb) - 1);
      if (e == 0) return {b[eb+mb], 31'd0};
      return {b[eb+mb], 31'd0} | (32'(int'(e) - bias + FP32_BIAS) << 23)
             | (32'(m) << (23 - mb));
   endfunction

   function automatic quant_result_type quantize_model(input logic [2:0] fmt,
                                                       input logic [31:0] x);
      quant_result_type r;
      logic [31:0]      y;
      logic [15:0]      h;
      logic [7:0]       b;
      r = '0;
      case (fmt)
         FMT_BF16: begin
            y = x + 32'h7fff + 32'(x[16]);
            r.code         = {16'd0, y[31:16]};
            r.dequant_bits = {y[31:16], 16'd0};
         end
         FMT_TF32: begin
            y = (x + 32'h0fff + 32'(x[13])) & ~32'h1fff;
            r.code         = y;
            r.dequant_bits = y;
         end
         FMT_F16: begin
            h = f16_encode(x);
            r.code         = {16'd0, h};
            r.dequant_bits = f16_decode(h);
         end
         FMT_E4M3: begin
            b = fp8_encode(x, 4, 3, 7);
            r.code         = {24'd0, b};
            r.dequant_bits = fp8_decode(b, 4, 3, 7);
         end
         FMT_E5M2: begin
            b = fp8_encode(x, 5, 2, 15);
            r.code         = {24'd0, b};
            r.dequant_bits = fp8_decode(b, 5, 2, 15);
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------- stimulus ----------------

   // biased toward exponents near the narrow ranges and exact rounding ties
   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      int unsigned tie_bit;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: ;
         1, 2: v[30:23] = 8'($urandom_range(100, 150));
         3: begin
            v[30:23] = 8'($urandom_range(100, 150));
            case ($urandom_range(0, 3))
               0: tie_bit = 12;
               1: tie_bit = 15;
               2: tie_bit = 19;
               default: tie_bit = 20;
            endcase
            v = v & ~((32'd1 << tie_bit) - 32'd1);
            v[tie_bit] = 1'b1;
         end
         4: begin
            case ($urandom_range(0, 3))
               0: v[30:23] = 8'h00;
               1: v[30:23] = 8'hff;
               2: v[30:23] = 8'h01;
               default: v[30:23] = 8'hfe;
            endcase
         end
         default: begin
            v[30:23] = 8'($urandom_range(100, 150));
            v[22:0]  = 23'h7f_ffff ^ 23'($urandom_range(0, 15));
         end
      endcase
      return v;
   endfunction

   function automatic bit source_idles();
      case (pace)
         PACE_SINK_HEAVY:   return $urandom_range(0, 99) < 21;
         PACE_SOURCE_HEAVY: return $urandom_range(0, 99) < 57;
         default:           return 1'b0;
      endcase
   endfunction

   function automatic bit sink_stalls();
      case (pace)
         PACE_SINK_HEAVY:   return $urandom_range(0, 99) < 57;
         PACE_SOURCE_HEAVY: return $urandom_range(0, 99) < 21;
         default:           return 1'b0;
      endcase
   endfunction

   task automatic wait_all_accepted();
      while (n_accepted != n_pushed) @(posedge clock);
   endtask

   task automatic wait_drained();
      wait_all_accepted();
      while (expected_quant.size() != 0) @(posedge clock);
   endtask

   task automatic write_format(input logic [2:0] fmt);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_format = fmt;
   endtask

   task automatic run_phase();
      for (int p = 0; p < 3; p++) begin
         pace = pace_type'(p);
         if (pace == PACE_SINK_HEAVY) begin
            for (int i = 0; i < NUM_EDGE; i++) begin
               operand_queue.push_back(EDGE_OPERANDS[i]);
               n_pushed++;
            end
         end
         for (int i = 0; i < RANDOM_CHUNK; i++) begin
            operand_queue.push_back(random_operand());
            n_pushed++;
         end
         wait_all_accepted();
      end
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_phase();                  // format from reset
      write_format(FMT_F16);
      run_phase();
      write_format(FMT_TF32);
      run_phase();
      write_format(FMT_E4M3);
      run_phase();
      write_format(FMT_E5M2);
      run_phase();
      write_format(FMT_SPARE_LO);
      run_phase();
      write_format(FMT_SPARE_MID);
      run_phase();
      write_format(FMT_SPARE_HI);
      run_phase();
      write_format(FMT_BF16);
      run_phase();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_quant.push_back(quantize_model(active_format, req_value_bits));
            n_accepted++;
         end
         // payload may only change when no transaction is held
         if (!req_valid || !req_stall) begin
            if (operand_queue.size() != 0 && !source_idles()) begin
               req_valid      <= 1'b1;
               req_value_bits <= operand_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      quant_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_quant.size() == 0) begin
               $error("unexpected transaction: code %h dequant_bits %h",
                      rsp_code, rsp_dequant_bits);
               mismatches++;
            end else begin
               want = expected_quant.pop_front();
               if (rsp_code !== want.code) begin
                  $error("code: expected %h, actual %h", want.code, rsp_code);
                  mismatches++;
               end
               if (rsp_dequant_bits !== want.dequant_bits) begin
                  $error("dequant_bits: expected %h, actual %h",
                         want.dequant_bits, rsp_dequant_bits);
                  mismatches++;
               end
            end
         end
         rsp_stall <= sink_stalls();
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
src/fp32mfq_pkg.sv
src/fp32_multi_format_quantizer_unit.sv
tb/sv/tb.sv
